// File: src/frm_pkg.sv
// frame rate monitor shared types and constants
// no dependencies; imported by the top level, the event engine, the checker and the bench

package frm_pkg;

  localparam int CFG_W      = 32;
  localparam int PERIOD_W   = 48;
  localparam int AVG_W      = 56;
  localparam int RATE_W     = 48;
  localparam int FRAC_BITS  = 8;
  localparam int RATE_SHIFT = 16;
  localparam int RES_DATA_W = RATE_W + AVG_W + PERIOD_W;

  localparam logic [CFG_W-1:0] WIN_RESET = 32'd1000000;

  // event kinds carried on tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_END   = 1'b1;

  typedef struct packed {
    logic                window_closed;
    logic [RATE_W-1:0]   rate_q8;
    logic [AVG_W-1:0]    average_period_q8;
    logic [PERIOD_W-1:0] frame_period;
  } result_t;

endpackage

// File: src/frame_rate_monitor.sv
// frame rate monitor top level: input queue, event engine, result register
// uses frm_pkg, frm_queue and frm_back
//
// usage
//   slave stream carries one event per beat: tuser is the kind (0 frame start,
//   1 frame end), tdata holds the timestamp. master stream returns one beat per
//   event with the last frame period, the window average period (q8) and the
//   rate (window length over average, q8); tuser flags a closed window.
//   cfg_we/cfg_wdata write the window length (reset 1000000 ticks) while idle.
// event handling
//   one event at a time; a start beat passes the difference and accumulate steps,
//   an end beat also the window check, and the result register takes the beat once
//   free; only then is the next event taken. a window close or a new window length
//   runs the serial divider (one bit a cycle over max(TIME_WIDTH + 9, 57) bits) for
//   the average and, unless it is zero, the rate.
// reset
//   clears all accumulators, the cached average and rate, and both streams.
// stall
//   a two-beat queue keeps accepting while the result register waits;
//   s_tready drops once the queue is full.

module frame_rate_monitor import frm_pkg::*; #(
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((TIME_WIDTH+7)/8)*8-1:0]     s_tdata,   // timestamp
  input  logic                                s_tuser,   // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [RES_DATA_W-1:0]               m_tdata,   // frame_period, average_period_q8, rate_q8
  output logic                                m_tuser,   // window_closed
  input  logic                                cfg_we,
  input  logic [CFG_W-1:0]                    cfg_wdata
);

  localparam int EVW = TIME_WIDTH + 1;

  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic [EVW-1:0] q_data;
  result_t        res;

  assign s_tready = !q_full;

  frm_queue #(
    .W     (EVW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data ({s_tuser, s_tdata[TIME_WIDTH-1:0]}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  frm_back #(
    .TW (TIME_WIDTH),
    .CW (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ev_valid  (!q_empty),
    .ev_kind   (q_data[EVW-1]),
    .ev_stamp  (q_data[TIME_WIDTH-1:0]),
    .ev_pop    (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {res.rate_q8, res.average_period_q8, res.frame_period};
  assign m_tuser = res.window_closed;

endmodule

// File: src/frm_queue.sv
// small register fifo between the accepting front and the event engine
// depends on nothing outside this file

module frm_queue #(
  parameter int W     = 49,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] slot [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/frm_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on nothing outside this file

module frm_div #(
  parameter int QW  = 57,
  parameter int DVW = 56
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [QW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [QW-1:0]  quotient
);

  localparam int CNTW = $clog2(QW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DVW:0]    rem;
  logic [DVW-1:0]  dvs;
  logic [QW-1:0]   quo;

  logic [DVW:0] trial;
  logic         fits;

  // remainder stays below the divisor, so its top bit is always clear
  assign trial    = {rem[DVW-1:0], quo[QW-1]};
  assign fits     = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(QW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, dvs} : trial;
      quo <= {quo[QW-2:0], fits};
    end
  end

endmodule

// File: src/frm_back.sv
// event engine: timestamp accumulators, window check, average and rate
// uses frm_pkg and frm_div; drives the result register

module frm_back import frm_pkg::*; #(
  parameter int TW = 48,
  parameter int CW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             ev_valid,
  input  logic             ev_kind,
  input  logic [TW-1:0]    ev_stamp,
  output logic             ev_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int QW   = (TW + FRAC_BITS + 1 > AVG_W + 1) ? TW + FRAC_BITS + 1 : AVG_W + 1;
  localparam int CMPW = (TW + 1 > CFG_W) ? TW + 1 : CFG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_ACCUM, S_CHECK, S_AVG_GO, S_AVG, S_RATE_GO, S_RATE, S_EMIT
  } state_t;

  state_t state;

  logic             op;
  logic [TW-1:0]    stamp;
  logic [TW-1:0]    diff_start;
  logic [TW-1:0]    diff_end;
  logic [TW-1:0]    last_start;
  logic [TW-1:0]    last_end;
  logic [TW-1:0]    busy_sum;
  logic [TW-1:0]    idle_sum;
  logic [CW-1:0]    frame_count;
  logic [TW-1:0]    period_hold;
  logic [TW:0]      window_total;
  logic [CW-1:0]    window_count;
  logic [CFG_W-1:0] window_length;
  logic [AVG_W-1:0] avg_q;
  logic [RATE_W-1:0] rate_q;
  logic             dirty;
  logic             closed;

  logic [TW:0]       busy_add;
  logic [TW:0]       idle_add;
  logic [TW-1:0]     busy_next;
  logic [TW-1:0]     idle_next;
  logic [TW:0]       total;
  logic              close_hit;
  logic [TW+PERIOD_W-1:0] period_ext;

  logic              div_start;
  logic [QW-1:0]     div_dividend;
  logic [AVG_W-1:0]  div_divisor;
  logic              div_done;
  logic [QW-1:0]     div_quo;
  logic [AVG_W-1:0]  avg_sat;

  assign busy_add  = {1'b0, busy_sum} + {1'b0, diff_start};
  assign idle_add  = {1'b0, idle_sum} + {1'b0, diff_end};
  assign busy_next = busy_add[TW] ? '1 : busy_add[TW-1:0];
  assign idle_next = idle_add[TW] ? '1 : idle_add[TW-1:0];
  assign total     = {1'b0, busy_sum} + {1'b0, idle_sum};
  assign close_hit = (CMPW'(total) >= CMPW'(window_length));
  assign period_ext = {{PERIOD_W{1'b0}}, period_hold};

  assign ev_pop = (state == S_IDLE) && ev_valid;

  // average divides the q8 total by the count, rate divides window q16 by the average
  assign div_start    = (state == S_AVG_GO) || ((state == S_RATE_GO) && (avg_q != '0));
  assign div_dividend = (state == S_AVG_GO) ? QW'({window_total, {FRAC_BITS{1'b0}}})
                                            : QW'({window_length, {RATE_SHIFT{1'b0}}});
  assign div_divisor  = (state == S_AVG_GO)
                      ? ((window_count == '0) ? AVG_W'(1) : AVG_W'(window_count))
                      : avg_q;
  assign avg_sat      = (|div_quo[QW-1:AVG_W]) ? '1 : div_quo[AVG_W-1:0];

  frm_div #(
    .QW  (QW),
    .DVW (AVG_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_start    <= '0;
      last_end      <= '0;
      busy_sum      <= '0;
      idle_sum      <= '0;
      frame_count   <= '0;
      period_hold   <= '0;
      window_total  <= '0;
      window_count  <= '0;
      window_length <= WIN_RESET;
      avg_q         <= '0;
      rate_q        <= '0;
      dirty         <= 1'b0;
      closed        <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      // emit state loads the next beat itself when the current one leaves
      if (res_valid && res_ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ev_valid) begin
            op    <= ev_kind;
            stamp <= ev_stamp;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          // differences wrap at the timestamp width
          diff_start <= stamp - last_start;
          diff_end   <= stamp - last_end;
          state      <= S_ACCUM;
        end
        S_ACCUM: begin
          case (op)
            OP_START: begin
              period_hold <= diff_start;
              idle_sum    <= idle_next;
              if (!(&frame_count)) begin
                frame_count <= frame_count + 1'b1;
              end
              last_start <= stamp;
              closed     <= 1'b0;
              state      <= dirty ? S_AVG_GO : S_EMIT;
            end
            OP_END: begin
              busy_sum <= busy_next;
              last_end <= stamp;
              state    <= S_CHECK;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_CHECK: begin
          if (close_hit) begin
            window_total <= total;
            window_count <= frame_count;
            busy_sum     <= '0;
            idle_sum     <= '0;
            frame_count  <= '0;
            closed       <= 1'b1;
            state        <= S_AVG_GO;
          end else begin
            closed <= 1'b0;
            state  <= dirty ? S_AVG_GO : S_EMIT;
          end
        end
        S_AVG_GO: state <= S_AVG;
        S_AVG: begin
          if (div_done) begin
            avg_q <= avg_sat;
            state <= S_RATE_GO;
          end
        end
        S_RATE_GO: begin
          if (avg_q == '0) begin
            rate_q <= '0;
            dirty  <= 1'b0;
            state  <= S_EMIT;
          end else begin
            state <= S_RATE;
          end
        end
        S_RATE: begin
          if (div_done) begin
            rate_q <= div_quo[RATE_W-1:0];
            dirty  <= 1'b0;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res_valid || res_ready) begin
            res.window_closed     <= closed;
            res.rate_q8           <= rate_q;
            res.average_period_q8 <= avg_q;
            res.frame_period      <= period_ext[PERIOD_W-1:0];
            res_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // a new window length invalidates the cached rate
      if (cfg_we) begin
        window_length <= cfg_wdata;
        dirty         <= 1'b1;
      end
    end
  end

endmodule

// File: src/frm_checker.sv
// port-level checks for the frame rate monitor
// uses frm_pkg; bound to frame_rate_monitor below

module frm_checker import frm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [RES_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // a stalled result beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // queue is empty after reset, so input side must be ready
  assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // a zero average forces a zero rate
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[PERIOD_W+AVG_W-1:PERIOD_W] == '0) |->
      (m_tdata[RES_DATA_W-1:PERIOD_W+AVG_W] == '0))
    else $error("nonzero rate with zero average");

endmodule

bind frame_rate_monitor frm_checker u_frm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for frame_rate_monitor: event streams in, per-event results out
// depends on frm_pkg and frame_rate_monitor; expected results come from an in-bench predictor

module tb_top import frm_pkg::*; ();

  localparam logic [63:0] TICK_MASK  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] COUNT_MASK = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] AVG_SAT    = 64'h00FF_FFFF_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // predicts period / average / rate per event and checks returned beats in order
  class frame_rate_scoreboard;
    logic [63:0] win_len;
    logic [63:0] last_start, last_end, busy_sum, idle_sum, frame_count;
    logic [63:0] period_hold, window_total, window_count;
    result_t     expected_q[$];
    int unsigned events_seen, results_seen, closes_seen, avg_saturated, mismatches;

    function new();
      win_len = 64'(WIN_RESET);
      last_start = 0; last_end = 0; busy_sum = 0; idle_sum = 0; frame_count = 0;
      period_hold = 0; window_total = 0; window_count = 0;
      events_seen = 0; results_seen = 0; closes_seen = 0; avg_saturated = 0;
      mismatches = 0;
    endfunction

    function void set_window(logic [CFG_W-1:0] v);
      win_len = 64'(v);
    endfunction

    function void note_event(logic op, logic [PERIOD_W-1:0] ts);
      logic [63:0] t, d, total, cnt, quo, rem, frac, avg, rate;
      result_t r;
      t = 64'(ts);
      r.window_closed = 1'b0;
      events_seen++;
      if (op == OP_START) begin
        period_hold = (t - last_start) & TICK_MASK;
        d = (t - last_end) & TICK_MASK;
        idle_sum = (idle_sum + d > TICK_MASK) ? TICK_MASK : idle_sum + d;
        if (frame_count < COUNT_MASK) frame_count++;
        last_start = t;
      end else begin
        d = (t - last_start) & TICK_MASK;
        busy_sum = (busy_sum + d > TICK_MASK) ? TICK_MASK : busy_sum + d;
        last_end = t;
        total = busy_sum + idle_sum;
        if (total >= win_len) begin
          window_total = total;
          window_count = frame_count;
          busy_sum = 0;
          idle_sum = 0;
          frame_count = 0;
          r.window_closed = 1'b1;
          closes_seen++;
        end
      end
      // empty snapshot divides by one
      cnt = (window_count == 0) ? 64'd1 : window_count;
      quo = window_total / cnt;
      rem = window_total % cnt;
      frac = (rem << FRAC_BITS) / cnt;
      if (quo > (AVG_SAT >> FRAC_BITS)) begin
        avg = AVG_SAT;
      end else begin
        avg = (quo << FRAC_BITS) + frac;
        if (avg > AVG_SAT) avg = AVG_SAT;
      end
      if (avg == AVG_SAT) avg_saturated++;
      rate = (avg == 0) ? 64'd0 : ((win_len << RATE_SHIFT) / avg) & TICK_MASK;
      r.frame_period      = period_hold[PERIOD_W-1:0];
      r.average_period_q8 = avg[AVG_W-1:0];
      r.rate_q8           = rate[RATE_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: period %h avg %h rate %h closed %b",
                   got.frame_period, got.average_period_q8, got.rate_q8, got.window_closed);
        return;
      end
      want = expected_q.pop_front();
      if (got.frame_period !== want.frame_period ||
          got.average_period_q8 !== want.average_period_q8 ||
          got.rate_q8 !== want.rate_q8 ||
          got.window_closed !== want.window_closed) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d mismatch: period %h/%h avg %h/%h rate %h/%h",
                    " closed %b/%b (exp/got)"},
                   results_seen, want.frame_period, got.frame_period,
                   want.average_period_q8, got.average_period_q8,
                   want.rate_q8, got.rate_q8, want.window_closed, got.window_closed);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [PERIOD_W-1:0]       s_tdata = '0;   // timestamp
  logic                      s_tuser = 1'b0; // op
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [RES_DATA_W-1:0]     m_tdata;        // frame_period, average_period_q8, rate_q8
  logic                      m_tuser;        // window_closed
  logic                      cfg_we = 1'b0;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned cycles = 0;
  frame_rate_scoreboard sb;

  frame_rate_monitor u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result({m_tuser, m_tdata});
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.expected_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // present one event beat, with optional idle cycles ahead of it
  task automatic send_event(input logic op, input logic [PERIOD_W-1:0] ts);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ts;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(op, ts);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_window(v);
  endtask

  // mostly start/end pairs with periods scaled to the window, plus noise events
  task automatic run_phase(input logic [CFG_W-1:0] win, input int mode, input int n_items);
    logic [63:0]         base, per, busy, cur_t;
    logic [PERIOD_W-1:0] ts;
    logic                op;
    int                  k;
    s_tvalid <= 1'b0;
    drain();
    write_window(win);
    if (win < 16) base = 64'($urandom_range(50, 1));
    else base = 64'(win) / 64'($urandom_range(20, 3)) + 64'd1;
    // half the phases start just below the timestamp wrap
    if ($urandom_range(1, 0)) cur_t = 64'h1_0000_0000_0000 - base * 64'd16;
    else cur_t = 64'({$urandom, $urandom}) & TICK_MASK;
    k = 0;
    while (k < n_items) begin
      if ((k % 64) < 10) begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end else begin
        case (mode)
          1: begin src_idle_pct = 46; sink_stall_pct = 0; end
          2: begin src_idle_pct = 0; sink_stall_pct = 46; end
          3: begin src_idle_pct = 37; sink_stall_pct = 37; end
          default: begin src_idle_pct = 0; sink_stall_pct = 0; end
        endcase
      end
      if ($urandom_range(99) < 15) begin
        op = 1'($urandom_range(1, 0));
        if ($urandom_range(1, 0)) ts = PERIOD_W'({$urandom, $urandom});
        else ts = PERIOD_W'(cur_t - 64'($urandom_range(3, 0)));
        if ($urandom_range(1, 0)) cur_t = 64'(ts);
        send_event(op, ts);
        k++;
      end else begin
        per  = base + 64'($urandom) % (base / 64'd4 + 64'd1);
        busy = 64'($urandom) % (per + 64'd1);
        send_event(OP_START, PERIOD_W'(cur_t));
        send_event(OP_END, PERIOD_W'(cur_t + busy));
        cur_t = cur_t + per;
        k += 2;
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed events at the reset window length
    send_event(OP_START, 48'h0000_0000_0000);
    send_event(OP_END,   48'h0000_0000_0064);
    send_event(OP_START, 48'hFFFF_FFFF_FFFF);
    send_event(OP_END,   48'h0000_0000_0005);  // busy time wraps past zero
    send_event(OP_START, 48'h0000_0000_0004);  // idle gap wraps backwards
    send_event(OP_END,   48'h0000_0000_0003);  // one frame, huge total: average saturates
    send_event(OP_END,   48'h0000_0000_0003);  // window with no frames divides by one
    send_event(OP_START, 48'h0000_0000_0003);
    send_event(OP_START, 48'h0000_0000_0003);  // zero period
    send_event(OP_START, 48'h8000_0000_0000);
    send_event(OP_START, 48'hFFFF_FFFF_FFFF);  // idle sum saturates
    send_event(OP_END,   48'hFFFF_FFFF_FFFF);
    send_event(OP_START, 48'h0000_0000_03E8);
    send_event(OP_END,   48'h0000_0000_05DC);
    send_event(OP_START, 48'h5555_5555_5555);
    send_event(OP_END,   48'hAAAA_AAAA_AAAA);
    send_event(OP_START, 48'hAAAA_AAAA_AAAA);
    send_event(OP_END,   48'hFFFF_FFFF_FFFE);

    run_phase(32'd1000, 0, 230);
    run_phase(32'd1, 1, 230);
    run_phase(32'hFFFF_FFFF, 2, 230);
    run_phase(32'd0, 3, 230);             // window closes on every end event
    run_phase(32'd5000, 0, 230);
    run_phase($urandom_range(100000, 100), 1, 230);
    run_phase(32'h8000_0000, 2, 230);
    run_phase($urandom_range(2000, 1), 3, 230);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d events over 9 window lengths (0, 1, all ones among them)",
             sb.events_seen);
    $display("%0d beats checked, %0d windows closed, %0d saturated averages, %0d mismatches",
             sb.results_seen, sb.closes_seen, sb.avg_saturated, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/frm_pkg.sv
src/frm_queue.sv
src/frm_div.sv
src/frm_back.sv
src/frame_rate_monitor.sv
src/frm_checker.sv
test/tb_top.sv
